// ===== rtl/gpc_pkg.sv =====
package gpc_pkg;

  localparam int MAX_EDGE_DEF = 128;
  localparam logic [7:0] EDGE_RST = 8'd100;

  typedef struct packed {
    logic cell_open;
    logic last_cell;
  } in_beat_t;

  typedef struct packed {
    logic conducts;
    logic shape_error;
  } out_beat_t;

  // neighbour direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

endpackage

// ===== rtl/gpc_nbr.sv =====
module gpc_nbr #(
  parameter int MAX_EDGE = gpc_pkg::MAX_EDGE_DEF,
  localparam int ADDR_W = $clog2(MAX_EDGE * MAX_EDGE),
  localparam int COL_W = $clog2(MAX_EDGE)
) (
  input  logic [1:0]        dir,
  input  logic [ADDR_W-1:0] p,
  input  logic [COL_W-1:0]  col,
  input  logic [ADDR_W-1:0] edge_n,
  input  logic [COL_W-1:0]  edge_m1,
  output logic              nb_valid,
  output logic [ADDR_W-1:0] nb_addr
);

  always_comb begin
    nb_valid = 1'b0;
    nb_addr  = p;
    case (dir)
      gpc_pkg::DIR_UP: begin
        nb_valid = (p >= edge_n);
        nb_addr  = p - edge_n;
      end
      gpc_pkg::DIR_DOWN: begin
        nb_valid = 1'b1;
        nb_addr  = p + edge_n;
      end
      gpc_pkg::DIR_LEFT: begin
        nb_valid = (col != '0);
        nb_addr  = p - ADDR_W'(1);
      end
      gpc_pkg::DIR_RIGHT: begin
        nb_valid = (col != edge_m1);
        nb_addr  = p + ADDR_W'(1);
      end
      default: begin
        nb_valid = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/grid_percolation_check_core.sv =====
// channel | dir | handshake          | payload
// cfg     | in  | cfg_we             | cfg_data (grid edge)
// in      | in  | in_valid/in_stall  | in_beat  (cell_open, last_cell)
// out     | out | out_valid/out_stall| out_beat (conducts, shape_error)
// Loading takes one cell beat per cycle. If the last beat gives a good shape
// and an edge above one, a breadth-first search runs over the cell memory:
// top-row open cells are marked and queued, then each popped cell queues its
// open unreached neighbours. No cell beat is taken during the search.
// Reset is synchronous; marks are cleared as each cell is loaded, so no sweep.
// A pending result holds under out_stall; the next search end waits for it.
module grid_percolation_check_core #(
  parameter int MAX_EDGE = gpc_pkg::MAX_EDGE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  gpc_pkg::in_beat_t in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output gpc_pkg::out_beat_t out_beat
);

  localparam int CAP    = MAX_EDGE * MAX_EDGE;
  localparam int ADDR_W = $clog2(CAP);
  localparam int COL_W  = $clog2(MAX_EDGE);
  localparam int CNT_W  = $clog2(CAP + 2);
  localparam int PTR_W  = $clog2(CAP + 1);
  localparam int Q_W    = ADDR_W + COL_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEED_RD = 3'd1;
  localparam logic [2:0] S_SEED_WR = 3'd2;
  localparam logic [2:0] S_POP     = 3'd3;
  localparam logic [2:0] S_POP_WT  = 3'd4;
  localparam logic [2:0] S_NB_RD   = 3'd5;
  localparam logic [2:0] S_NB_CHK  = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [1:0]        cell_mem [CAP];
  logic [Q_W-1:0]    q_mem    [CAP];

  logic [2:0]        st_r, st_nxt;
  logic [7:0]        edge_r;
  logic [15:0]       sq_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [COL_W-1:0]  c_r, c_nxt, col_r, col_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [1:0]        nb_r, nb_nxt;
  logic [16:0]       thr_r, thr_nxt;
  logic              res_c_r, res_c_nxt, res_e_r, res_e_nxt;
  logic              ov_r, ov_nxt;
  gpc_pkg::out_beat_t ob_r, ob_nxt;

  logic [1:0]        rd_data_r;
  logic [Q_W-1:0]    q_rd_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en, q_we;
  logic [1:0]        wr_data;
  logic [Q_W-1:0]    q_wdata;

  logic              in_acc;
  logic [ADDR_W-1:0] edge_n;
  logic [COL_W-1:0]  edge_m1;
  logic              nb_valid;
  logic [ADDR_W-1:0] nb_addr;
  logic              shape_ok;
  logic [CNT_W-1:0]  cnt_inc;
  logic [COL_W-1:0]  q_col;

  assign in_stall  = (st_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_beat  = ob_r;
  assign edge_n    = ADDR_W'(edge_r);
  assign edge_m1   = COL_W'(edge_r - 8'd1);

  // count after this beat, saturating one past capacity
  assign cnt_inc  = (32'(cnt_r) <= 32'(CAP)) ? cnt_r + CNT_W'(1) : cnt_r;

  assign shape_ok = (edge_r != 8'd0) && (32'(edge_r) <= 32'(MAX_EDGE))
                    && (32'(cnt_inc) == 32'(sq_r));

  always_comb begin
    case (nb_r)
      gpc_pkg::DIR_LEFT:  q_col = col_r - COL_W'(1);
      gpc_pkg::DIR_RIGHT: q_col = col_r + COL_W'(1);
      default:            q_col = col_r;
    endcase
  end

  gpc_nbr #(.MAX_EDGE(MAX_EDGE)) u_nbr (
    .dir      (nb_r),
    .p        (p_r),
    .col      (col_r),
    .edge_n   (edge_n),
    .edge_m1  (edge_m1),
    .nb_valid (nb_valid),
    .nb_addr  (nb_addr)
  );

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    c_nxt     = c_r;
    col_nxt   = col_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    nb_nxt    = nb_r;
    thr_nxt   = thr_r;
    res_c_nxt = res_c_r;
    res_e_nxt = res_e_r;
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    rd_addr   = q_r;
    wr_en     = 1'b0;
    wr_addr   = q_r;
    wr_data   = 2'b11;
    q_we      = 1'b0;
    q_wdata   = {q_r, c_r};

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (32'(cnt_r) < 32'(CAP)) begin
            wr_en   = 1'b1;
            wr_addr = cnt_r[ADDR_W-1:0];
            wr_data = {1'b0, in_beat.cell_open};
          end
          cnt_nxt = cnt_inc;
          if (in_beat.last_cell) begin
            cnt_nxt  = '0;
            head_nxt = '0;
            tail_nxt = '0;
            c_nxt    = '0;
            thr_nxt  = {1'b0, sq_r} - 17'(edge_r);
            if (!shape_ok) begin
              res_c_nxt = 1'b0;
              res_e_nxt = 1'b1;
              st_nxt    = S_FIN;
            end else if (edge_r == 8'd1) begin
              res_c_nxt = 1'b1;
              res_e_nxt = 1'b0;
              st_nxt    = S_FIN;
            end else begin
              res_e_nxt = 1'b0;
              st_nxt    = S_SEED_RD;
            end
          end
        end
      end
      S_SEED_RD: begin
        rd_addr = ADDR_W'(c_r);
        st_nxt  = S_SEED_WR;
      end
      S_SEED_WR: begin
        if (rd_data_r[0]) begin
          wr_en    = 1'b1;
          wr_addr  = ADDR_W'(c_r);
          q_we     = 1'b1;
          q_wdata  = {ADDR_W'(c_r), c_r};
          tail_nxt = tail_r + PTR_W'(1);
        end
        c_nxt  = c_r + COL_W'(1);
        st_nxt = (c_r == edge_m1) ? S_POP : S_SEED_RD;
      end
      S_POP: begin
        if (head_r == tail_r) begin
          res_c_nxt = 1'b0;
          st_nxt    = S_FIN;
        end else begin
          head_nxt = head_r + PTR_W'(1);
          st_nxt   = S_POP_WT;
        end
      end
      S_POP_WT: begin
        p_nxt   = q_rd_r[Q_W-1:COL_W];
        col_nxt = q_rd_r[COL_W-1:0];
        nb_nxt  = gpc_pkg::DIR_UP;
        if (17'(q_rd_r[Q_W-1:COL_W]) >= thr_r) begin
          res_c_nxt = 1'b1;
          st_nxt    = S_FIN;
        end else begin
          st_nxt = S_NB_RD;
        end
      end
      S_NB_RD: begin
        if (nb_valid) begin
          rd_addr = nb_addr;
          q_nxt   = nb_addr;
          st_nxt  = S_NB_CHK;
        end else begin
          nb_nxt = nb_r + 2'd1;
          st_nxt = (nb_r == gpc_pkg::DIR_RIGHT) ? S_POP : S_NB_RD;
        end
      end
      S_NB_CHK: begin
        // open and not yet reached
        if (rd_data_r == 2'b01) begin
          wr_en    = 1'b1;
          wr_addr  = q_r;
          q_we     = 1'b1;
          q_wdata  = {q_r, q_col};
          tail_nxt = tail_r + PTR_W'(1);
        end
        nb_nxt = nb_r + 2'd1;
        st_nxt = (nb_r == gpc_pkg::DIR_RIGHT) ? S_POP : S_NB_RD;
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          ob_nxt = '{conducts: res_c_r, shape_error: res_e_r};
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= cell_mem[rd_addr];
    if (q_we) begin
      q_mem[tail_r[ADDR_W-1:0]] <= q_wdata;
    end
    q_rd_r <= q_mem[head_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      edge_r <= gpc_pkg::EDGE_RST;
      sq_r   <= 16'({8'd0, gpc_pkg::EDGE_RST} * {8'd0, gpc_pkg::EDGE_RST});
      cnt_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      ov_r   <= ov_nxt;
      if (cfg_we) begin
        edge_r <= cfg_data;
        sq_r   <= {8'd0, cfg_data} * {8'd0, cfg_data};
      end
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    col_r   <= col_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    nb_r    <= nb_nxt;
    thr_r   <= thr_nxt;
    res_c_r <= res_c_nxt;
    res_e_r <= res_e_nxt;
    ob_r    <= ob_nxt;
  end

  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("queue head passed tail");

  a_no_load_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("cell beat taken during search");

  a_err_no_conduct: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !(ob_r.conducts && ob_r.shape_error)) else $error("error with conducts");

  a_fin_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && !ov_r) |=> ov_r) else $error("result not raised");

endmodule
